[hw/rtl/spp_pkg.sv]
// Package for the stepper position PID core: constants, the register index codes,
// the configuration, item and result types, the sequencer states and a rounding helper.
// It has no dependencies of its own.
`default_nettype none

package spp_pkg;

    // Encoder counts in one mechanical turn.
    localparam int ANGLE_COUNTS = 16384;

    localparam logic signed [17:0] ANGLE_HALF = 18'(ANGLE_COUNTS / 2);
    localparam logic signed [24:0] ANGLE_MUL  = 25'(ANGLE_COUNTS);
    localparam logic signed [16:0] STEP_HALF  = 17'sd32768;
    localparam logic signed [31:0] ERR_BOUND  = 32'sd1638;
    localparam logic signed [35:0] LEAD_BASE  = 36'sd82;
    localparam logic signed [35:0] DRIVE_MAX  = 36'sd262143;
    localparam logic signed [35:0] DRIVE_MIN  = -36'sd262144;
    localparam logic signed [57:0] S32_MAX    = 58'sd2147483647;
    localparam logic signed [57:0] S32_MIN    = -58'sd2147483648;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic [2:0] {
        REG_STEP_SIZE,
        REG_PROP_GAIN,
        REG_INTEG_GAIN,
        REG_DERIV_GAIN,
        REG_FILT_KEEP,
        REG_FILT_NEW,
        REG_INTEG_LIMIT,
        REG_CURRENT_LIMIT
    } spp_reg_idx_t;

    typedef struct packed {
        logic [9:0]  step_size;
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] deriv_gain;
        logic [7:0]  filt_keep;
        logic [7:0]  filt_new;
        logic [23:0] integ_limit;
        logic [11:0] current_limit;
    } spp_cfg_t;

    localparam spp_cfg_t CFG_RESET = '{
        step_size:     10'd5,
        prop_gain:     16'd30,
        integ_gain:    16'd10,
        deriv_gain:    16'd250,
        filt_keep:     8'd100,
        filt_new:      8'd28,
        integ_limit:   24'd1000000,
        current_limit: 12'd3000
    };

    typedef struct packed {
        logic        enable;
        logic [13:0] encoder_angle;
        logic [15:0] step_count;
    } spp_item_t;

    typedef struct packed {
        logic signed [18:0] drive_angle;
        logic [11:0]        current;
        logic               error_clamped;
    } spp_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_TGT,
        ST_MEAS,
        ST_ERR,
        ST_KD,
        ST_INT,
        ST_DER,
        ST_SUM,
        ST_OUT
    } spp_state_t;

    // Signed division by 2^k, truncating towards zero.
    function automatic logic signed [MUL_P_W-1:0] div_pow2(
        input logic signed [MUL_P_W-1:0] x,
        input int unsigned               k
    );
        logic [MUL_P_W-1:0] bias;
        bias = x[MUL_P_W-1] ? ((MUL_P_W'(1) << k) - MUL_P_W'(1)) : '0;
        return (x + $signed(bias)) >>> k;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/spp_mul.sv]
// Shared signed multiplier of the stepper position PID core, with a registered product.
// Depends on spp_pkg for the operand widths.
`default_nettype none

module spp_mul (
    input  wire logic                               aclk,
    input  wire logic signed [spp_pkg::MUL_A_W-1:0] a,
    input  wire logic signed [spp_pkg::MUL_B_W-1:0] b,
    output logic signed [spp_pkg::MUL_P_W-1:0]      p_reg
);
    import spp_pkg::*;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule

`default_nettype wire

[hw/rtl/spp_core.sv]
// Sequencer and datapath of the stepper position PID core. It drives the shared
// multiplier one operand pair per step. Depends on spp_pkg and spp_mul.
`default_nettype none

module spp_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire spp_pkg::spp_cfg_t  cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire spp_pkg::spp_item_t in_item,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output spp_pkg::spp_res_t       res
);
    import spp_pkg::*;

    spp_state_t state_reg, state_next;

    // Controller state kept between ticks.
    logic [15:0]        prev_step_reg;
    logic [31:0]        offset_reg;
    logic [13:0]        prev_enc_reg;
    logic [23:0]        turn_reg;
    logic [31:0]        prev_unw_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] deriv_reg;

    // Per-tick working registers.
    logic               en_reg;
    logic [13:0]        y_reg;
    logic [15:0]        s_reg;
    logic [31:0]        target_reg;
    logic [31:0]        meas_reg;
    logic signed [11:0] err_reg;
    logic               clamped_reg;
    logic signed [31:0] vel_reg;
    logic [23:0]        fngd_reg;
    logic signed [33:0] kd_reg;
    logic signed [33:0] sum_reg;
    logic signed [18:0] drv_pos_reg;
    logic signed [18:0] drv_neg_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod_reg;

    spp_mul u_mul (
        .aclk  (aclk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod_reg)
    );

    // Unwrapping of both counters.
    logic signed [16:0] ds;
    logic signed [17:0] dy;
    logic [31:0]        offset_next;
    logic [23:0]        turn_next;
    logic [31:0]        step_span;

    always_comb begin
        ds        = $signed({1'b0, s_reg}) - $signed({1'b0, prev_step_reg});
        dy        = $signed({4'b0, y_reg}) - $signed({4'b0, prev_enc_reg});
        step_span = {6'b0, cfg.step_size, 16'b0};
        if (ds < -STEP_HALF) begin
            offset_next = offset_reg + step_span;
        end else if (ds > STEP_HALF) begin
            offset_next = offset_reg - step_span;
        end else begin
            offset_next = offset_reg;
        end
        if (dy > ANGLE_HALF) begin
            turn_next = turn_reg - 24'd1;
        end else if (dy < -ANGLE_HALF) begin
            turn_next = turn_reg + 24'd1;
        end else begin
            turn_next = turn_reg;
        end
    end

    // Error clamp and velocity.
    logic signed [31:0] err_full;
    logic signed [11:0] err_next;
    logic               clamped_next;

    always_comb begin
        err_full = $signed(target_reg - meas_reg);
        if (err_full > ERR_BOUND) begin
            err_next     = 12'(ERR_BOUND);
            clamped_next = 1'b1;
        end else if (err_full < -ERR_BOUND) begin
            err_next     = 12'(-ERR_BOUND);
            clamped_next = 1'b1;
        end else begin
            err_next     = err_full[11:0];
            clamped_next = 1'b0;
        end
    end

    // Drive angle candidates for either sign of the PID output.
    logic signed [35:0] adv;
    logic signed [35:0] drv_pos_full;
    logic signed [35:0] drv_neg_full;
    logic signed [18:0] drv_pos_next;
    logic signed [18:0] drv_neg_next;

    always_comb begin
        adv          = (36'(vel_reg) <<< 1) + 36'(vel_reg);
        drv_pos_full = $signed({22'b0, y_reg}) + LEAD_BASE + adv;
        drv_neg_full = $signed({22'b0, y_reg}) - LEAD_BASE + adv;
        if (drv_pos_full > DRIVE_MAX) begin
            drv_pos_next = 19'(DRIVE_MAX);
        end else if (drv_pos_full < DRIVE_MIN) begin
            drv_pos_next = 19'(DRIVE_MIN);
        end else begin
            drv_pos_next = drv_pos_full[18:0];
        end
        if (drv_neg_full > DRIVE_MAX) begin
            drv_neg_next = 19'(DRIVE_MAX);
        end else if (drv_neg_full < DRIVE_MIN) begin
            drv_neg_next = 19'(DRIVE_MIN);
        end else begin
            drv_neg_next = drv_neg_full[18:0];
        end
    end

    // Integral update with its symmetric limit.
    logic signed [MUL_P_W-1:0] int_step;
    logic signed [33:0]        acc_sum;
    logic signed [33:0]        lim;
    logic signed [31:0]        acc_next;

    always_comb begin
        int_step = div_pow2(prod_reg, 5);
        lim      = $signed({10'b0, cfg.integ_limit});
        acc_sum  = 34'(acc_reg) + int_step[33:0];
        if (acc_sum > lim) begin
            acc_next = lim[31:0];
        end else if (acc_sum < -lim) begin
            acc_next = 32'(-lim);
        end else begin
            acc_next = acc_sum[31:0];
        end
    end

    // Filtered derivative, saturated to 32 bits.
    logic signed [MUL_P_W-1:0] dv;
    logic signed [MUL_P_W-1:0] deriv_full;
    logic signed [31:0]        deriv_next;

    always_comb begin
        dv         = div_pow2(prod_reg, 3);
        deriv_full = MUL_P_W'(kd_reg) - dv;
        if (deriv_full > S32_MAX) begin
            deriv_next = 32'(S32_MAX);
        end else if (deriv_full < S32_MIN) begin
            deriv_next = 32'(S32_MIN);
        end else begin
            deriv_next = deriv_full[31:0];
        end
    end

    logic signed [MUL_P_W-1:0] kd_full;
    assign kd_full = div_pow2(prod_reg, 7);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) begin
                state_next = in_item.enable ? ST_WRAP : ST_OUT;
            end
            ST_WRAP: state_next = ST_TGT;
            ST_TGT:  state_next = ST_MEAS;
            ST_MEAS: state_next = ST_ERR;
            ST_ERR:  state_next = ST_KD;
            ST_KD:   state_next = ST_INT;
            ST_INT:  state_next = ST_DER;
            ST_DER:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT: if (res_ready) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and multiplier operand selection.
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_WRAP: begin
                mul_a = $signed({17'b0, s_reg});
                mul_b = $signed({15'b0, cfg.step_size});
            end
            ST_TGT: begin
                mul_a = MUL_A_W'($signed(turn_reg));
                mul_b = ANGLE_MUL;
            end
            ST_MEAS: begin
                mul_a = $signed({17'b0, cfg.deriv_gain});
                mul_b = $signed({17'b0, cfg.filt_new});
            end
            ST_ERR: begin
                mul_a = MUL_A_W'(deriv_reg);
                mul_b = $signed({17'b0, cfg.filt_keep});
            end
            ST_KD: begin
                mul_a = $signed({17'b0, cfg.integ_gain});
                mul_b = MUL_B_W'(err_reg);
            end
            ST_INT: begin
                mul_a = MUL_A_W'(vel_reg);
                mul_b = $signed({1'b0, fngd_reg});
            end
            ST_DER: begin
                mul_a = $signed({17'b0, cfg.prop_gain});
                mul_b = MUL_B_W'(err_reg);
            end
            ST_SUM: begin
            end
            ST_OUT: res_valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_step_reg <= '0;
            offset_reg    <= '0;
            prev_enc_reg  <= '0;
            turn_reg      <= '0;
            prev_unw_reg  <= '0;
            acc_reg       <= '0;
            deriv_reg     <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: if (in_valid) begin
                    en_reg <= in_item.enable;
                    y_reg  <= in_item.encoder_angle;
                    s_reg  <= in_item.step_count;
                end
                ST_WRAP: begin
                    prev_step_reg <= s_reg;
                    offset_reg    <= offset_next;
                    turn_reg      <= turn_next;
                end
                ST_TGT:  target_reg <= offset_reg + prod_reg[31:0];
                ST_MEAS: meas_reg <= {18'b0, y_reg} + prod_reg[31:0];
                ST_ERR: begin
                    err_reg     <= err_next;
                    clamped_reg <= clamped_next;
                    vel_reg     <= $signed(meas_reg - prev_unw_reg);
                    fngd_reg    <= prod_reg[23:0];
                end
                ST_KD: begin
                    kd_reg      <= kd_full[33:0];
                    drv_pos_reg <= drv_pos_next;
                    drv_neg_reg <= drv_neg_next;
                end
                ST_INT: acc_reg <= acc_next;
                ST_DER: deriv_reg <= deriv_next;
                ST_SUM: begin
                    sum_reg      <= prod_reg[33:0] + 34'(acc_reg) + 34'(deriv_reg);
                    prev_enc_reg <= y_reg;
                    prev_unw_reg <= meas_reg;
                end
                ST_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // PID output: sign selects the drive angle, magnitude is limited.
    logic signed [MUL_P_W-1:0] u_full;
    logic signed [26:0]        u;
    logic [26:0]               u_mag;

    always_comb begin
        u_full = div_pow2(MUL_P_W'(sum_reg), 7);
        u      = u_full[26:0];
        u_mag  = u[26] ? 27'(-u) : 27'(u);
        res    = '0;
        if (en_reg) begin
            if (u > 27'sd0) begin
                res.drive_angle = drv_pos_reg;
            end else if (u < 27'sd0) begin
                res.drive_angle = drv_neg_reg;
            end else begin
                res.drive_angle = $signed({5'b0, y_reg});
            end
            res.current       = (u_mag > {15'b0, cfg.current_limit}) ?
                                cfg.current_limit : u_mag[11:0];
            res.error_clamped = clamped_reg;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stepper_position_pid_core.sv]
// Top level of the stepper position PID core: stream ports, configuration registers
// and the result register. Depends on spp_pkg and spp_core.
//
// One request in carries a control tick: an enable flag, the calibrated 14-bit encoder
// angle and the 16-bit step counter. One request out follows for every tick, carrying
// the drive angle, the coil current and a flag that is set when the position error hit
// its clamp. An enabled tick passes from acceptance to the next acceptance through the
// accepting state, seven sequencer steps that each issue one product to the single shared
// 33 x 25 bit multiplier, one step that sums the loop terms and one step that hands the
// result to the result register. A disabled tick skips straight to that last step,
// returns zeros and leaves the controller state untouched. The result register lets
// the next tick be accepted while an earlier result is still waiting downstream; the
// sequencer holds its finished result until that register is free. Configuration
// writes are taken at any time but should only be issued while the core is idle.
`default_nettype none

module stepper_position_pid_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input ticks.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // encoder_angle[13:0], step_count[29:14], zero
    input  wire logic        s_tuser,   // enable
    // Results.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // drive_angle[18:0], current[30:19], zero
    output logic             m_tuser,   // error_clamped
    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import spp_pkg::*;

    spp_cfg_t  cfg_reg;
    spp_item_t in_item;
    spp_res_t  res;
    logic      res_valid;
    logic      res_ready;
    logic      m_tvalid_reg;
    spp_res_t  out_reg;

    // Registers are always writable; software is expected to write only when idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            case (spp_reg_idx_t'(cfg_index))
                REG_STEP_SIZE:     cfg_reg.step_size     <= cfg_data[9:0];
                REG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_data[15:0];
                REG_INTEG_GAIN:    cfg_reg.integ_gain    <= cfg_data[15:0];
                REG_DERIV_GAIN:    cfg_reg.deriv_gain    <= cfg_data[15:0];
                REG_FILT_KEEP:     cfg_reg.filt_keep     <= cfg_data[7:0];
                REG_FILT_NEW:      cfg_reg.filt_new      <= cfg_data[7:0];
                REG_INTEG_LIMIT:   cfg_reg.integ_limit   <= cfg_data;
                REG_CURRENT_LIMIT: cfg_reg.current_limit <= cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.enable        = s_tuser;
    assign in_item.encoder_angle = s_tdata[13:0];
    assign in_item.step_count    = s_tdata[29:14];

    spp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The result register takes a new result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg.current, out_reg.drive_angle};
    assign m_tuser  = out_reg.error_clamped;

endmodule

`default_nettype wire

[hw/rtl/spp_checker.sv]
// Port-level checker for the stepper position PID core, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module spp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The sequencer does not take a tick in the cycle after taking one.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("tick accepted on consecutive cycles");

    // A tick taken into an empty pipe cannot produce its result on the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind stepper_position_pid_core spp_checker u_spp_checker (.*);

`default_nettype wire
